// File: sv/positional_array_list_macros.svh
// positional_array_list_macros.svh: assertion macros for the list block
// used by the datapath; expects signals named clk and rst in scope
`ifndef POSITIONAL_ARRAY_LIST_MACROS_SVH
`define POSITIONAL_ARRAY_LIST_MACROS_SVH

// same-cycle implication, idle during reset
`define PAL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, idle during reset
`define PAL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/pal_pkg.sv
// pal_pkg: sizes, codes and controller/datapath interface types for the list block
// no dependencies
package pal_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int POS_W      = CNT_W;
  localparam int MODE_W     = 3;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 3;

  typedef logic [DATA_WIDTH-1:0] word_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // request codes
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_BACK  = 3'd0,
    MODE_PUSH_FRONT = 3'd1,
    MODE_POP_BACK   = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_INSERT     = 3'd4,
    MODE_ERASE      = 3'd5,
    MODE_FIND       = 3'd6,
    MODE_DUMP       = 3'd7
  } mode_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // source of the target slot
  typedef enum logic [1:0] {AT_ZERO, AT_COUNT, AT_LAST, AT_POS} at_sel_t;

  // walking pointer update
  typedef enum logic [2:0] {
    PTR_HOLD, PTR_ZERO, PTR_COUNT, PTR_AT, PTR_INC, PTR_DEC
  } ptr_op_t;

  // memory read address source
  typedef enum logic [1:0] {RD_PTR, RD_PTR_DEC, RD_PTR_INC, RD_AT} rd_sel_t;

  // memory write: shift a read word to ptr, or store the new word at the target
  typedef enum logic {WR_SHIFT, WR_NEW} wr_sel_t;

  typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_op_t;

  // result field sources
  typedef enum logic [2:0] {
    OSEL_ZERO, OSEL_PUSH, OSEL_RES, OSEL_SCAN, OSEL_PEND
  } osel_t;

  typedef struct packed {
    logic    load_req;
    logic    set_at;
    at_sel_t at_sel;
    ptr_op_t ptr_op;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    cnt_op_t cnt_op;
    logic    save_en;
    logic    pend_set;
    logic    pend_clr;
    logic    out_load;
    osel_t   out_sel;
    status_t out_status;
    logic    out_last;
  } pal_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_ins_ok;
    logic pos_era_ok;
    logic open_more;
    logic close_more;
    logic scan_more;
    logic scan_last;
    logic match;
    logic pend_valid;
    logic out_free;
  } pal_stat_t;

  // sign-extend the request value to the stored word width
  function automatic word_t in_word(input logic [VALUE_W-1:0] v);
    logic [63:0] w;
    w = {{(64-VALUE_W){v[VALUE_W-1]}}, v};
    return w[DATA_WIDTH-1:0];
  endfunction

  // stored word to the result data field
  function automatic logic [VALUE_W-1:0] out_word(input word_t w);
    logic [63:0] z;
    z = 64'(w);
    return z[VALUE_W-1:0];
  endfunction

endpackage

// File: sv/pal_ctrl.sv
// pal_ctrl: request sequencer for the list block
// depends on pal_pkg; drives the datapath by pal_cmd_t, reads pal_stat_t
module pal_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [pal_pkg::MODE_W-1:0] mode,
  input  pal_pkg::pal_stat_t        stat,
  output pal_pkg::pal_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_OPEN_RD, S_OPEN_WR, S_DEL_RD, S_DEL_SAVE,
    S_CLOSE_RD, S_CLOSE_WR, S_SCAN_RD, S_SCAN_CHK, S_SCAN_FIN, S_EMIT
  } state_t;

  state_t             state, state_next;
  pal_pkg::mode_t     mode_q;
  pal_pkg::osel_t     emit_sel, emit_sel_next;
  pal_pkg::status_t   emit_status, emit_status_next;

  assign in_ready = (state == S_IDLE);

  // next state and datapath commands
  always_comb begin
    cmd              = '0;
    state_next       = state;
    emit_sel_next    = emit_sel;
    emit_status_next = emit_status;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next       = S_EMIT;
        emit_sel_next    = pal_pkg::OSEL_ZERO;
        emit_status_next = pal_pkg::ST_OK;
        unique case (mode_q) inside
          pal_pkg::MODE_PUSH_BACK, pal_pkg::MODE_PUSH_FRONT: begin
            if (stat.full) begin
              emit_status_next = pal_pkg::ST_FULL;
            end else begin
              cmd.set_at = 1'b1;
              if (mode_q == pal_pkg::MODE_PUSH_BACK) begin
                cmd.at_sel = pal_pkg::AT_COUNT;
              end else begin
                cmd.at_sel = pal_pkg::AT_ZERO;
              end
              cmd.ptr_op = pal_pkg::PTR_COUNT;
              state_next = S_OPEN_RD;
            end
          end
          pal_pkg::MODE_POP_BACK, pal_pkg::MODE_POP_FRONT: begin
            if (stat.empty) begin
              emit_status_next = pal_pkg::ST_EMPTY;
            end else begin
              cmd.set_at = 1'b1;
              if (mode_q == pal_pkg::MODE_POP_BACK) begin
                cmd.at_sel = pal_pkg::AT_LAST;
              end else begin
                cmd.at_sel = pal_pkg::AT_ZERO;
              end
              state_next = S_DEL_RD;
            end
          end
          pal_pkg::MODE_INSERT: begin
            if (stat.full) begin
              emit_status_next = pal_pkg::ST_FULL;
            end else if (!stat.pos_ins_ok) begin
              emit_status_next = pal_pkg::ST_BADPOS;
            end else begin
              cmd.set_at = 1'b1;
              cmd.at_sel = pal_pkg::AT_POS;
              cmd.ptr_op = pal_pkg::PTR_COUNT;
              state_next = S_OPEN_RD;
            end
          end
          pal_pkg::MODE_ERASE: begin
            if (!stat.pos_era_ok) begin
              emit_status_next = pal_pkg::ST_BADPOS;
            end else begin
              cmd.set_at = 1'b1;
              cmd.at_sel = pal_pkg::AT_POS;
              state_next = S_DEL_RD;
            end
          end
          pal_pkg::MODE_FIND: begin
            cmd.ptr_op   = pal_pkg::PTR_ZERO;
            cmd.pend_clr = 1'b1;
            state_next   = S_SCAN_RD;
          end
          pal_pkg::MODE_DUMP: begin
            if (stat.empty) begin
              emit_status_next = pal_pkg::ST_EMPTY;
            end else begin
              cmd.ptr_op = pal_pkg::PTR_ZERO;
              state_next = S_SCAN_RD;
            end
          end
        endcase
      end
      // open a gap: move entries up from the end down to the target
      S_OPEN_RD: begin
        if (stat.open_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = pal_pkg::RD_PTR_DEC;
          state_next = S_OPEN_WR;
        end else begin
          cmd.wr_en        = 1'b1;
          cmd.wr_sel       = pal_pkg::WR_NEW;
          cmd.cnt_op       = pal_pkg::CNT_INC;
          emit_sel_next    = pal_pkg::OSEL_PUSH;
          emit_status_next = pal_pkg::ST_OK;
          state_next       = S_EMIT;
        end
      end
      S_OPEN_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = pal_pkg::WR_SHIFT;
        cmd.ptr_op = pal_pkg::PTR_DEC;
        state_next = S_OPEN_RD;
      end
      // fetch the removed entry
      S_DEL_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = pal_pkg::RD_AT;
        state_next = S_DEL_SAVE;
      end
      S_DEL_SAVE: begin
        cmd.save_en = 1'b1;
        cmd.ptr_op  = pal_pkg::PTR_AT;
        state_next  = S_CLOSE_RD;
      end
      // close the gap: move later entries down by one
      S_CLOSE_RD: begin
        if (stat.close_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = pal_pkg::RD_PTR_INC;
          state_next = S_CLOSE_WR;
        end else begin
          cmd.cnt_op       = pal_pkg::CNT_DEC;
          emit_sel_next    = pal_pkg::OSEL_RES;
          emit_status_next = pal_pkg::ST_OK;
          state_next       = S_EMIT;
        end
      end
      S_CLOSE_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = pal_pkg::WR_SHIFT;
        cmd.ptr_op = pal_pkg::PTR_INC;
        state_next = S_CLOSE_RD;
      end
      // walk the list for find and dump
      S_SCAN_RD: begin
        if (stat.scan_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = pal_pkg::RD_PTR;
          state_next = S_SCAN_CHK;
        end else if (mode_q == pal_pkg::MODE_DUMP) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_SCAN_FIN;
        end
      end
      S_SCAN_CHK: begin
        if (mode_q == pal_pkg::MODE_DUMP) begin
          if (stat.out_free) begin
            cmd.out_load   = 1'b1;
            cmd.out_sel    = pal_pkg::OSEL_SCAN;
            cmd.out_status = pal_pkg::ST_OK;
            cmd.out_last   = stat.scan_last;
            cmd.ptr_op     = pal_pkg::PTR_INC;
            state_next     = S_SCAN_RD;
          end
        end else if (!stat.match) begin
          cmd.ptr_op = pal_pkg::PTR_INC;
          state_next = S_SCAN_RD;
        end else if (!stat.pend_valid) begin
          // first match is held until we know whether another follows
          cmd.pend_set = 1'b1;
          cmd.ptr_op   = pal_pkg::PTR_INC;
          state_next   = S_SCAN_RD;
        end else if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_sel    = pal_pkg::OSEL_PEND;
          cmd.out_status = pal_pkg::ST_OK;
          cmd.pend_set   = 1'b1;
          cmd.ptr_op     = pal_pkg::PTR_INC;
          state_next     = S_SCAN_RD;
        end
      end
      // final find result: held match or not found
      S_SCAN_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = 1'b1;
          if (stat.pend_valid) begin
            cmd.out_sel    = pal_pkg::OSEL_PEND;
            cmd.out_status = pal_pkg::ST_OK;
          end else begin
            cmd.out_sel    = pal_pkg::OSEL_ZERO;
            cmd.out_status = pal_pkg::ST_NOTFOUND;
          end
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_sel    = emit_sel;
          cmd.out_status = emit_status;
          cmd.out_last   = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state, result selection and status, and registered request code
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state       <= state_next;
      emit_sel    <= emit_sel_next;
      emit_status <= emit_status_next;
      if (cmd.load_req) begin
        mode_q <= pal_pkg::mode_t'(mode);
      end
    end
  end

endmodule

// File: sv/pal_dp.sv
// pal_dp: entry memory, count, pointers and result register of the list block
// depends on pal_pkg and positional_array_list_macros.svh
`include "positional_array_list_macros.svh"

module pal_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  pal_pkg::pal_cmd_t            cmd,
  output pal_pkg::pal_stat_t           stat,
  input  logic [pal_pkg::VALUE_W-1:0]  value,
  input  logic [pal_pkg::POS_W-1:0]    position,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pal_pkg::VALUE_W-1:0]  data_out,
  output logic [pal_pkg::IDX_W-1:0]    entry_index,
  output logic [pal_pkg::STATUS_W-1:0] status,
  output logic [pal_pkg::CNT_W-1:0]    entry_count,
  output logic                         last
);

  localparam int CNT_W = pal_pkg::CNT_W;
  localparam int IDX_W = pal_pkg::IDX_W;

  pal_pkg::word_t mem [pal_pkg::DEPTH];
  pal_pkg::word_t rd_data;
  pal_pkg::word_t val_q;
  pal_pkg::word_t save;
  pal_pkg::cnt_t  pos_q;
  pal_pkg::cnt_t  cnt;
  pal_pkg::cnt_t  ptr;
  pal_pkg::idx_t  at_q;
  pal_pkg::idx_t  pend_idx;
  logic           pend_valid;

  pal_pkg::cnt_t  ptr_inc, ptr_dec, cnt_dec;
  pal_pkg::idx_t  rd_addr, wr_addr, at_next;
  pal_pkg::word_t wr_data;
  logic           out_free;

  assign ptr_inc  = ptr + CNT_W'(1);
  assign ptr_dec  = ptr - CNT_W'(1);
  assign cnt_dec  = cnt - CNT_W'(1);
  assign out_free = !out_valid || out_ready;

  // status toward the controller
  always_comb begin
    stat.full       = (cnt == CNT_W'(pal_pkg::DEPTH));
    stat.empty      = (cnt == '0);
    stat.pos_ins_ok = (pos_q <= cnt);
    stat.pos_era_ok = (pos_q < cnt);
    stat.open_more  = (ptr > CNT_W'(at_q));
    stat.close_more = (ptr_inc < cnt);
    stat.scan_more  = (ptr < cnt);
    stat.scan_last  = (ptr_inc == cnt);
    stat.match      = (rd_data == val_q);
    stat.pend_valid = pend_valid;
    stat.out_free   = out_free;
  end

  // memory addresses, write data and next target slot
  always_comb begin
    case (cmd.rd_sel)
      pal_pkg::RD_PTR:     rd_addr = ptr[IDX_W-1:0];
      pal_pkg::RD_PTR_DEC: rd_addr = ptr_dec[IDX_W-1:0];
      pal_pkg::RD_PTR_INC: rd_addr = ptr_inc[IDX_W-1:0];
      default:             rd_addr = at_q;
    endcase
    if (cmd.wr_sel == pal_pkg::WR_NEW) begin
      wr_addr = at_q;
      wr_data = val_q;
    end else begin
      wr_addr = ptr[IDX_W-1:0];
      wr_data = rd_data;
    end
    case (cmd.at_sel)
      pal_pkg::AT_COUNT: at_next = cnt[IDX_W-1:0];
      pal_pkg::AT_LAST:  at_next = cnt_dec[IDX_W-1:0];
      pal_pkg::AT_POS:   at_next = pos_q[IDX_W-1:0];
      default:           at_next = '0;
    endcase
  end

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // request, target, pointer and held words
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      val_q <= pal_pkg::in_word(value);
      pos_q <= position;
    end
    if (cmd.set_at) begin
      at_q <= at_next;
    end
    if (cmd.save_en) begin
      save <= rd_data;
    end
    if (cmd.pend_set) begin
      pend_idx <= ptr[IDX_W-1:0];
    end
    case (cmd.ptr_op)
      pal_pkg::PTR_ZERO:  ptr <= '0;
      pal_pkg::PTR_COUNT: ptr <= cnt;
      pal_pkg::PTR_AT:    ptr <= CNT_W'(at_q);
      pal_pkg::PTR_INC:   ptr <= ptr_inc;
      pal_pkg::PTR_DEC:   ptr <= ptr_dec;
      default:            ptr <= ptr;
    endcase
  end

  // entry count and held-match flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      pend_valid <= 1'b0;
    end else begin
      case (cmd.cnt_op)
        pal_pkg::CNT_INC: cnt <= cnt + CNT_W'(1);
        pal_pkg::CNT_DEC: cnt <= cnt_dec;
        default:          cnt <= cnt;
      endcase
      if (cmd.pend_set) begin
        pend_valid <= 1'b1;
      end else if (cmd.pend_clr) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status      <= cmd.out_status;
      entry_count <= cnt;
      last        <= cmd.out_last;
      case (cmd.out_sel)
        pal_pkg::OSEL_PUSH: begin
          data_out    <= '0;
          entry_index <= at_q;
        end
        pal_pkg::OSEL_RES: begin
          data_out    <= pal_pkg::out_word(save);
          entry_index <= at_q;
        end
        pal_pkg::OSEL_SCAN: begin
          data_out    <= pal_pkg::out_word(rd_data);
          entry_index <= ptr[IDX_W-1:0];
        end
        pal_pkg::OSEL_PEND: begin
          data_out    <= pal_pkg::out_word(val_q);
          entry_index <= pend_idx;
        end
        default: begin
          data_out    <= '0;
          entry_index <= '0;
        end
      endcase
    end
  end

  // checks
  `PAL_ASSERT_IMP(a_cnt_bound, 1'b1, cnt <= CNT_W'(pal_pkg::DEPTH), "entry count above depth")
  `PAL_ASSERT_IMP(a_load_free, cmd.out_load, out_free, "result loaded over an untaken result")
  `PAL_ASSERT_IMP(a_wr_in_list, cmd.wr_en, (CNT_W'(wr_addr) <= cnt) && !cmd.rd_en, "bad write")
  `PAL_ASSERT_NXT(a_res_count, cmd.out_load, out_valid && (entry_count == $past(cnt)), "bad count")

endmodule

// File: sv/positional_array_list.sv
// positional_array_list: top level of the bounded ordered list block
// depends on pal_pkg, pal_ctrl and pal_dp
//
// Holds up to 16 signed 32-bit entries in a single-port-write, registered-read
// memory and serves one request at a time: push/pop at either end, insert or
// erase at a position, find a value, or dump the list. A request is taken only
// while the sequencer is idle; a finished result may still wait in the output
// register meanwhile. Every shifted entry costs one read and one write. Dump
// reads the entries one at a time and waits whenever the output register is
// still occupied. Find reports each match in index order with last on the final
// one, holding each match until the next is seen.
module positional_array_list (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pal_pkg::MODE_W-1:0]   mode,
  input  logic signed [pal_pkg::VALUE_W-1:0] value,
  input  logic [pal_pkg::POS_W-1:0]    position,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [pal_pkg::VALUE_W-1:0] data_out,
  output logic [pal_pkg::IDX_W-1:0]    entry_index,
  output logic [pal_pkg::STATUS_W-1:0] status,
  output logic [pal_pkg::CNT_W-1:0]    entry_count,
  output logic                         last
);

  pal_pkg::pal_cmd_t  cmd;
  pal_pkg::pal_stat_t stat;
  logic [pal_pkg::VALUE_W-1:0] data_word;

  assign data_out = data_word;

  // request sequencer
  pal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage and result path
  pal_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .value       (value),
    .position    (position),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .data_out    (data_word),
    .entry_index (entry_index),
    .status      (status),
    .entry_count (entry_count),
    .last        (last)
  );

endmodule

// File: tb/pal_checker.sv
// pal_checker: watches both channels of the list block, predicts every result
// and compares field by field; depends on pal_pkg only
module pal_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [pal_pkg::MODE_W-1:0]     mode,
  input  logic [pal_pkg::VALUE_W-1:0]    value,
  input  logic [pal_pkg::POS_W-1:0]      position,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [pal_pkg::VALUE_W-1:0]    data_out,
  input  logic [pal_pkg::IDX_W-1:0]      entry_index,
  input  logic [pal_pkg::STATUS_W-1:0]   status,
  input  logic [pal_pkg::CNT_W-1:0]      entry_count,
  input  logic                           last,
  output int                             fail_count,
  output int                             replies_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [pal_pkg::VALUE_W-1:0] data;
    pal_pkg::idx_t               idx;
    pal_pkg::status_t            st;
    pal_pkg::cnt_t               cnt;
    logic                        lst;
  } reply_t;

  // shadow copy of the list and the replies still owed
  pal_pkg::word_t list_words [pal_pkg::DEPTH];
  int             list_len;
  reply_t         due_replies [$];

  // one printed line per mismatch
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  // queue one reply, entry count taken after the list update
  function automatic void owe_reply(logic [pal_pkg::VALUE_W-1:0] d, int i,
                                    pal_pkg::status_t s, logic l);
    reply_t r;
    r.data = d;
    r.idx  = pal_pkg::idx_t'(i);
    r.st   = s;
    r.cnt  = pal_pkg::cnt_t'(list_len);
    r.lst  = l;
    due_replies.push_back(r);
  endfunction

  // apply one request to the shadow list and queue its replies
  function automatic void apply_request(pal_pkg::mode_t m, pal_pkg::word_t v, int p);
    int             at;
    int             hits;
    int             k;
    pal_pkg::word_t w;
    case (m)
      pal_pkg::MODE_PUSH_BACK, pal_pkg::MODE_PUSH_FRONT, pal_pkg::MODE_INSERT: begin
        at = (m == pal_pkg::MODE_PUSH_BACK) ? list_len :
             (m == pal_pkg::MODE_PUSH_FRONT) ? 0 : p;
        // full is checked ahead of the position
        if (list_len >= pal_pkg::DEPTH) owe_reply('0, 0, pal_pkg::ST_FULL, 1'b1);
        else if (at > list_len) owe_reply('0, 0, pal_pkg::ST_BADPOS, 1'b1);
        else begin
          for (int i = list_len; i > at; i--) list_words[i] = list_words[i-1];
          list_words[at] = v;
          list_len++;
          owe_reply('0, at, pal_pkg::ST_OK, 1'b1);
        end
      end
      pal_pkg::MODE_POP_BACK, pal_pkg::MODE_POP_FRONT, pal_pkg::MODE_ERASE: begin
        at = (m == pal_pkg::MODE_POP_BACK) ? list_len - 1 :
             (m == pal_pkg::MODE_POP_FRONT) ? 0 : p;
        // erase on an empty list is a bad position, not empty
        if (list_len == 0 && m != pal_pkg::MODE_ERASE) begin
          owe_reply('0, 0, pal_pkg::ST_EMPTY, 1'b1);
        end else if (at >= list_len) begin
          owe_reply('0, 0, pal_pkg::ST_BADPOS, 1'b1);
        end else begin
          w = list_words[at];
          for (int i = at; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
          owe_reply(pal_pkg::out_word(w), at, pal_pkg::ST_OK, 1'b1);
        end
      end
      pal_pkg::MODE_FIND: begin
        hits = 0;
        for (int i = 0; i < list_len; i++) if (list_words[i] == v) hits++;
        if (hits == 0) owe_reply('0, 0, pal_pkg::ST_NOTFOUND, 1'b1);
        else begin
          k = 0;
          for (int i = 0; i < list_len; i++) begin
            if (list_words[i] == v) begin
              k++;
              owe_reply(list_words[i], i, pal_pkg::ST_OK, k == hits);
            end
          end
        end
      end
      default: begin
        if (list_len == 0) owe_reply('0, 0, pal_pkg::ST_EMPTY, 1'b1);
        else for (int i = 0; i < list_len; i++)
          owe_reply(list_words[i], i, pal_pkg::ST_OK, i == list_len - 1);
      end
    endcase
  endfunction

  // compare the result transaction first, then predict the accepted request
  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      fail_count  = 0;
      replies_due = 0;
      list_len    = 0;
      due_replies.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (due_replies.size() == 0) begin
          report_mismatch("result with none pending", data_out, '0);
        end else begin
          want = due_replies.pop_front();
          if (data_out !== want.data) report_mismatch("data_out", data_out, want.data);
          if (entry_index !== want.idx)
            report_mismatch("entry_index", 32'(entry_index), 32'(want.idx));
          if (status !== want.st)
            report_mismatch("status", 32'(status), 32'(want.st));
          if (entry_count !== want.cnt)
            report_mismatch("entry_count", 32'(entry_count), 32'(want.cnt));
          if (last !== want.lst)
            report_mismatch("last", 32'(last), 32'(want.lst));
        end
      end
      if (in_valid && in_ready) begin
        apply_request(pal_pkg::mode_t'(mode), pal_pkg::in_word(value), int'(position));
      end
      replies_due = due_replies.size();
    end
  end

endmodule

// File: tb/tb_top.sv
// tb_top: stimulus, receiver pacing and verdict for the list block
// depends on pal_pkg, positional_array_list and pal_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 600;
  localparam int DRAIN_CYCLES = 40;

  // phase kinds for the random part
  localparam int GROW  = 0;
  localparam int SHRINK = 1;
  localparam int MIXED = 2;

  // per-kind weights in request code order: push_back, push_front, pop_back,
  // pop_front, insert, erase, find, dump
  localparam int MODE_WEIGHT [3][8] = '{
    '{20, 15, 4, 4, 25, 8, 14, 10},
    '{4, 4, 15, 15, 5, 30, 15, 12},
    '{10, 10, 10, 10, 15, 15, 18, 12}
  };

  // small value pool so finds hit, with both extremes
  localparam logic [31:0] VALUE_POOL [8] = '{
    32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h7fff_ffff,
    32'h8000_0000, 32'h0000_0005, 32'h0000_04d2, 32'hffff_ffb3
  };

  logic                                 clk = 1'b0;
  logic                                 rst;
  logic                                 in_valid;
  logic                                 in_ready;
  logic [pal_pkg::MODE_W-1:0]           mode;
  logic signed [pal_pkg::VALUE_W-1:0]   value;
  logic [pal_pkg::POS_W-1:0]            position;
  logic                                 out_valid;
  logic                                 out_ready;
  logic signed [pal_pkg::VALUE_W-1:0]   data_out;
  logic [pal_pkg::IDX_W-1:0]            entry_index;
  logic [pal_pkg::STATUS_W-1:0]         status;
  logic [pal_pkg::CNT_W-1:0]            entry_count;
  logic                                 last;

  int fail_count;
  int replies_due;
  int cycle_count = 0;
  int fill_est = 0;
  bit idle_on = 1'b1;
  bit rx_quiet = 1'b0;
  bit hold_req = 1'b0;

  positional_array_list uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .value       (value),
    .position    (position),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .data_out    (data_out),
    .entry_index (entry_index),
    .status      (status),
    .entry_count (entry_count),
    .last        (last)
  );

  pal_checker list_chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .value       (value),
    .position    (position),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .data_out    (data_out),
    .entry_index (entry_index),
    .status      (status),
    .entry_count (entry_count),
    .last        (last),
    .fail_count  (fail_count),
    .replies_due (replies_due)
  );

  // 8 ns clock
  always #4ns clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // idle length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // offer one transaction, hold it until taken, then maybe idle
  task automatic send_req(pal_pkg::mode_t m, logic [31:0] v, int p);
    int gap;
    in_valid <= 1'b1;
    mode     <= m;
    value    <= v;
    position <= pal_pkg::POS_W'(p);
    // rough fill level, used only to aim positions
    case (m)
      pal_pkg::MODE_PUSH_BACK, pal_pkg::MODE_PUSH_FRONT:
        if (fill_est < pal_pkg::DEPTH) fill_est++;
      pal_pkg::MODE_INSERT: if (fill_est < pal_pkg::DEPTH && p <= fill_est) fill_est++;
      pal_pkg::MODE_POP_BACK, pal_pkg::MODE_POP_FRONT: if (fill_est > 0) fill_est--;
      pal_pkg::MODE_ERASE: if (p < fill_est) fill_est--;
      default: ;
    endcase
    do @(posedge clk); while (!in_ready);
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // one random request shaped by the phase kind
  task automatic random_req(int kind);
    int             r;
    int             acc;
    int             p;
    pal_pkg::mode_t m;
    logic [31:0]    v;
    r = $urandom_range(0, 99);
    acc = 0;
    m = pal_pkg::MODE_DUMP;
    for (int i = 7; i >= 0; i--) begin
      acc += MODE_WEIGHT[kind][i];
      if (100 - acc <= r) begin
        m = pal_pkg::mode_t'(i);
        break;
      end
    end
    v = ($urandom_range(0, 99) < 60) ? VALUE_POOL[$urandom_range(0, 7)] : $urandom();
    // mostly legal positions, some noise over the whole field
    if ($urandom_range(0, 99) < 12) p = $urandom_range(0, 31);
    else if (m == pal_pkg::MODE_INSERT) p = $urandom_range(0, fill_est);
    else if (m == pal_pkg::MODE_ERASE) p = (fill_est == 0) ? 0 : $urandom_range(0, fill_est - 1);
    else p = $urandom_range(0, 31);
    send_req(m, v, p);
  endtask

  // receiver pacing: random stalls, quiet stretches, one long hold-off
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_quiet) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  // stimulus and verdict
  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    mode     = pal_pkg::MODE_PUSH_BACK;
    value    = '0;
    position = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty-list errors
    send_req(pal_pkg::MODE_POP_BACK, 32'h0, 0);
    send_req(pal_pkg::MODE_POP_FRONT, 32'h0, 0);
    send_req(pal_pkg::MODE_ERASE, 32'h0, 0);
    send_req(pal_pkg::MODE_DUMP, 32'h0, 0);
    send_req(pal_pkg::MODE_FIND, 32'h0, 0);
    send_req(pal_pkg::MODE_INSERT, 32'h1, 1);

    // extremes of the value field
    send_req(pal_pkg::MODE_INSERT, 32'h8000_0000, 0);
    send_req(pal_pkg::MODE_PUSH_BACK, 32'h7fff_ffff, 0);
    send_req(pal_pkg::MODE_PUSH_FRONT, 32'hffff_ffff, 0);
    send_req(pal_pkg::MODE_ERASE, 32'h0, 3);

    // fill to capacity with repeated values
    for (int k = 0; k < 13; k++) begin
      case (k % 3)
        0: send_req(pal_pkg::MODE_PUSH_BACK, 32'h7fff_ffff, 0);
        1: send_req(pal_pkg::MODE_PUSH_FRONT, k, 0);
        default: send_req(pal_pkg::MODE_INSERT, 32'h7fff_ffff, fill_est);
      endcase
    end

    // full list: full beats a bad position on insert
    send_req(pal_pkg::MODE_PUSH_FRONT, 32'h1, 0);
    send_req(pal_pkg::MODE_INSERT, 32'h1, 31);
    send_req(pal_pkg::MODE_FIND, 32'h7fff_ffff, 0);
    send_req(pal_pkg::MODE_DUMP, 32'h0, 0);
    send_req(pal_pkg::MODE_ERASE, 32'h0, 15);

    // random phases
    for (int k = 0; k < 20; k++) random_req(SHRINK);
    idle_on = 1'b0;
    rx_quiet = 1'b1;
    for (int k = 0; k < 20; k++) random_req(GROW);
    rx_quiet = 1'b0;
    hold_req = 1'b1;
    for (int k = 0; k < 15; k++) random_req(MIXED);
    idle_on = 1'b1;
    for (int k = 0; k < 15; k++) random_req(MIXED);
    for (int k = 0; k < 12; k++) random_req(GROW);
    in_valid <= 1'b0;

    // drain and settle
    @(posedge clk);
    while (replies_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/pal_pkg.sv
sv/pal_ctrl.sv
sv/pal_dp.sv
sv/positional_array_list.sv
tb/pal_checker.sv
tb/tb_top.sv
